// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge outside reset
`define SMA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sma assertion failed");
// next-cycle implication
`define SMA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sma assertion failed");
`else
`define SMA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SMA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/sma_pkg.sv
// shared types and constants of the multichannel sample averager
package sma_pkg;

    localparam int CHANNELS_DEF   = 12;
    localparam int RING_DEPTH_DEF = 16;

    localparam int SAMPLE_W   = 12;
    localparam int CHAN_W     = 4;
    localparam int CHAN_LSB   = 26;
    localparam int CHAN_MSB   = 29;
    localparam int SAMPLE_LSB = 4;
    localparam int SAMPLE_MSB = 15;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_READ    = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic              action;
        logic [31:0]       data_word;
        logic [CHAN_W-1:0] read_channel;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SAMPLE_W-1:0] value;
    } out_item_t;

endpackage

// File: rtl/sma_ring_ram.sv
// sample ring store: one write port, one registered read port
module sma_ring_ram #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [sma_pkg::SAMPLE_W-1:0] wdata,
    input  logic                         re,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [sma_pkg::SAMPLE_W-1:0] rdata
);
    import sma_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/sma_mean_div.sv
// ring sum divided by the ring depth through a registered reciprocal multiply
module sma_mean_div #(
    parameter int RING_DEPTH = sma_pkg::RING_DEPTH_DEF,
    parameter int SUM_W      = sma_pkg::SAMPLE_W + $clog2(RING_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [SUM_W-1:0]             sum,
    output logic                         done,
    output logic [sma_pkg::SAMPLE_W-1:0] quotient
);
    import sma_pkg::*;

    // floor(x / d) == (x * ceil(2^s / d)) >> s for x < 2^SUM_W when s = SUM_W + clog2(d)
    localparam int SHIFT   = SUM_W + $clog2(RING_DEPTH);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

    logic [PROD_W-1:0] product_reg;
    logic              done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            product_reg <= PROD_W'(sum) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    assign done     = done_reg;
    assign quotient = product_reg[SHIFT +: SAMPLE_W];

endmodule

// File: rtl/multichannel_sample_averager.sv
// top level of the multichannel sample averager
//
// input channel (s_valid / s_ready / s_item): one item is either a converter
// data word (channel in bits 29:26, 12-bit sample in bits 15:4) or a read
// request for read_channel. every item gives exactly one result item on the
// m_valid / m_ready / m_item channel: sample stored, read answer or dropped.
// cfg_we / cfg_wdata set the filter mode: 0 returns the latest sample
// (slot 0), 1 returns the truncated mean of the channel's ring.
// steps per item, set by the single read port of the ring store:
//   data word: IDLE, DONE; raw read: IDLE, RAW, DONE; averaged read: IDLE,
//   SUM, MUL, DIV, DONE, as the averaged read fetches one ring entry a cycle
//   in SUM and then goes through the registered reciprocal multiply
// after reset the ring store is cleared one entry a cycle, all CHANNELS times
// 2^clog2(RING_DEPTH) entries (192 by default), with s_ready low meanwhile;
// write slots and the filter mode reset at once.
// a finished result waits in the output register while the next item is
// taken; if the receiver stalls, the item after that holds in its last step
// until the output register is free.
// all store accesses are issued in separate cycles, so no forwarding is needed
`include "assert_macros.svh"

module multichannel_sample_averager #(
    parameter int CHANNELS   = sma_pkg::CHANNELS_DEF,
    parameter int RING_DEPTH = sma_pkg::RING_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sma_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sma_pkg::out_item_t m_item,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);
    import sma_pkg::*;

    // sizes derived from the configuration
    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int RAM_DEPTH = CHANNELS * (2 ** SLOT_W);
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_W + SLOT_W;

    localparam logic [CHAN_W:0]   CH_LIMIT  = (CHAN_W + 1)'(CHANNELS);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(RAM_DEPTH - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RAW,
        S_SUM,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    out_item_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;
    logic                filter_mode_reg;
    logic [SLOT_W-1:0]   slot_reg [CHANNELS];

    // ring store ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // write slot update
    logic                slot_we;
    logic [CH_W-1:0]     slot_wch;
    logic [SLOT_W-1:0]   slot_wval;

    // mean unit
    logic                div_start;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;

    // decoded input item
    logic [CHAN_W-1:0]   in_ch;
    logic [SAMPLE_W-1:0] in_sample;
    logic                data_ch_ok;
    logic                rd_ch_ok;
    logic                accept;
    logic [SLOT_W-1:0]   cur_slot;
    logic [SLOT_W-1:0]   put_slot;

    assign in_ch      = s_item.data_word[CHAN_MSB:CHAN_LSB];
    assign in_sample  = s_item.data_word[SAMPLE_MSB:SAMPLE_LSB];
    assign data_ch_ok = {1'b0, in_ch} < CH_LIMIT;
    assign rd_ch_ok   = {1'b0, s_item.read_channel} < CH_LIMIT;
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign cur_slot   = slot_reg[in_ch[CH_W-1:0]];
    // raw mode always overwrites slot 0
    assign put_slot   = filter_mode_reg ? cur_slot : '0;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        ch_next      = ch_reg;
        sum_next     = sum_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        slot_we      = 1'b0;
        slot_wch     = in_ch[CH_W-1:0];
        slot_wval    = (cur_slot == SLOT_LAST) ? '0 : cur_slot + 1'b1;
        div_start    = 1'b0;

        // output register empties when the receiver takes the item
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // clearing pass over the whole ring store
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    priority if (s_item.action == ACT_DATA) begin
                        if (data_ch_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = {in_ch[CH_W-1:0], put_slot};
                            ram_wdata = in_sample;
                            slot_we   = 1'b1;
                            res_next  = '{status: ST_STORED, value: '0};
                        end else begin
                            res_next  = '{status: ST_DROPPED, value: '0};
                        end
                        state_next = S_DONE;
                    end else begin
                        ch_next   = s_item.read_channel[CH_W-1:0];
                        ram_raddr = {s_item.read_channel[CH_W-1:0], {SLOT_W{1'b0}}};
                        if (!rd_ch_ok) begin
                            // unknown channel answers zero
                            res_next   = '{status: ST_READ, value: '0};
                            state_next = S_DONE;
                        end else if (filter_mode_reg) begin
                            ram_re     = 1'b1;
                            idx_next   = CNT_W'(1);
                            sum_next   = '0;
                            state_next = S_SUM;
                        end else begin
                            ram_re     = 1'b1;
                            state_next = S_RAW;
                        end
                    end
                end
            end
            S_RAW: begin
                res_next   = '{status: ST_READ, value: ram_rdata};
                state_next = S_DONE;
            end
            S_SUM: begin
                // add the entry fetched last cycle, fetch the next one while any remain
                sum_next = sum_reg + SUM_W'(ram_rdata);
                if (idx_reg < CNT_END) begin
                    ram_re    = 1'b1;
                    ram_raddr = {ch_reg, idx_reg[SLOT_W-1:0]};
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = '{status: ST_READ, value: div_quot};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            m_valid_reg     <= 1'b0;
            filter_mode_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                slot_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                filter_mode_reg <= cfg_wdata;
            end
            if (slot_we) begin
                slot_reg[slot_wch] <= slot_wval;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        ch_reg     <= ch_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    sma_ring_ram #(
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sma_mean_div #(
        .RING_DEPTH (RING_DEPTH),
        .SUM_W      (SUM_W)
    ) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .sum      (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the ring store never sees a read and a write in one cycle
    `SMA_ASSERT_IMP(a_port_exclusive, aclk, aresetn, ram_we, !ram_re)
    // an averaged read of a valid channel starts the ring walk
    `SMA_ASSERT_NXT(a_avg_walk, aclk, aresetn,
        accept && s_item.action == ACT_READ && rd_ch_ok && filter_mode_reg,
        state_reg == S_SUM && idx_reg == CNT_W'(1))
    // a new result only appears from the hand-over step
    `SMA_ASSERT_IMP(a_result_source, aclk, aresetn,
        m_valid_reg && !$past(m_valid_reg && !m_ready), $past(state_reg) == S_DONE)
    // the mean unit answers only while a read is waiting on it
    `SMA_ASSERT_IMP(a_div_owner, aclk, aresetn, div_done, state_reg == S_DIV)

endmodule
